// ----- hw/rtl/flow_result_ring_cache_unit_macros.svh -----
// Assertion helpers for the bound checker file (frrc_checker).
`ifndef FLOW_RESULT_RING_CACHE_UNIT_MACROS_SVH
`define FLOW_RESULT_RING_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FRRC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("flow cache check failed");

// Next-cycle implication, disabled while reset is asserted
`define FRRC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("flow cache check failed");

`endif

// ----- hw/rtl/frrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package frrc_pkg;

    localparam int unsigned DEFAULT_CACHE_DEPTH = 128;

    // Item kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOMATCH   = 2'd1;
    localparam logic [1:0] STATUS_BADQUERY  = 2'd2;

    // Request beat
    typedef struct packed {
        logic              kind;
        logic [31:0]       src_addr;
        logic [31:0]       dst_addr;
        logic [31:0]       port_pair;
        logic [15:0]       sig_index;
        logic [7:0]        link_index;
        logic [7:0]        tos_index;
        logic signed [7:0] hop_dist;
        logic              fw_flag;
        logic              nat_flag;
        logic [31:0]       query_id;
        logic [31:0]       magic_word;
    } frrc_req_t;

    // Response beat
    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       echo_id;
        logic [15:0]       out_sig;
        logic [7:0]        out_link;
        logic [7:0]        out_tos;
        logic signed [7:0] out_dist;
        logic              out_fw;
        logic              out_nat;
    } frrc_rsp_t;

    // Stored flow record: key plus payload
    typedef struct packed {
        logic [31:0]       src;
        logic [31:0]       dst;
        logic [31:0]       ports;
        logic [15:0]       sig;
        logic [7:0]        link;
        logic [7:0]        tos;
        logic signed [7:0] hop;
        logic              fw;
        logic              nat;
    } frrc_entry_t;

    localparam int unsigned ENTRY_W = $bits(frrc_entry_t);

endpackage

`default_nettype wire

// ----- hw/rtl/frrc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port
module frrc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/flow_result_ring_cache_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake             Beat
// req       in   req_valid/req_stall   frrc_req_t (add or query)
// rsp       out  rsp_valid/rsp_stall   frrc_rsp_t (one per query)
// cfg       in   cfg_wr_en             cfg_wr_data -> expected magic
//
// An add needs no search: the record is written at the write pointer on accept.
// A query with a bad magic goes straight to the done state; a good query reads
// at most F entries, F = entries written so far (capped at CACHE_DEPTH), with the
// single RAM read port and comparator walking one entry per cycle, newest first.
// After reset the fill count is zero, so no clearing pass is needed.
// req_stall is high from a query's accept until its result enters the output
// register; a held result waits there while the next item is taken.
module flow_result_ring_cache_unit #(
    parameter int unsigned CACHE_DEPTH = frrc_pkg::DEFAULT_CACHE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [31:0]         cfg_wr_data,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire frrc_pkg::frrc_req_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output frrc_pkg::frrc_rsp_t      rsp
);

    import frrc_pkg::*;

    localparam int unsigned PTR_W = $clog2(CACHE_DEPTH);
    localparam int unsigned CNT_W = $clog2(CACHE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CACHE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CACHE_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [31:0]      magic_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             cmp_valid_reg, cmp_valid_next;
    frrc_req_t        qry_reg, qry_next;
    frrc_rsp_t        res_reg, res_next;
    frrc_rsp_t        rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             req_accept;
    logic             ram_wr_en;
    logic             ram_rd_en;
    frrc_entry_t      wr_entry;
    frrc_entry_t      rd_entry;
    logic             key_match;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Record written on an add
    assign ram_wr_en      = req_accept && (req.kind == KIND_ADD);
    assign wr_entry.src   = req.src_addr;
    assign wr_entry.dst   = req.dst_addr;
    assign wr_entry.ports = req.port_pair;
    assign wr_entry.sig   = req.sig_index;
    assign wr_entry.link  = req.link_index;
    assign wr_entry.tos   = req.tos_index;
    assign wr_entry.hop   = req.hop_dist;
    assign wr_entry.fw    = req.fw_flag;
    assign wr_entry.nat   = req.nat_flag;

    frrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_entry)
    );

    // Key compare on the entry read last cycle
    assign key_match = (rd_entry.src == qry_reg.src_addr)
                    && (rd_entry.dst == qry_reg.dst_addr)
                    && (rd_entry.ports == qry_reg.port_pair);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        rd_ptr_next    = rd_ptr_reg;
        issue_cnt_next = issue_cnt_reg;
        cmp_valid_next = 1'b0;
        qry_next       = qry_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_rd_en      = 1'b0;

        // output beat taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (req.kind == KIND_ADD)
                    begin
                        wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0
                                    : wr_ptr_reg + PTR_W'(1);
                        if (fill_reg != FULL_CNT)
                        begin
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        qry_next = req;
                        if (req.magic_word != magic_reg)
                        begin
                            res_next         = '0;
                            res_next.status  = STATUS_BADQUERY;
                            res_next.echo_id = req.query_id;
                            state_next       = ST_DONE;
                        end
                        else
                        begin
                            // start at the newest slot
                            rd_ptr_next    = (wr_ptr_reg == '0) ? LAST_SLOT
                                           : wr_ptr_reg - PTR_W'(1);
                            issue_cnt_next = '0;
                            state_next     = ST_SEARCH;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                if (cmp_valid_reg && key_match)
                begin
                    res_next.status   = STATUS_OK;
                    res_next.echo_id  = qry_reg.query_id;
                    res_next.out_sig  = rd_entry.sig;
                    res_next.out_link = rd_entry.link;
                    res_next.out_tos  = rd_entry.tos;
                    res_next.out_dist = rd_entry.hop;
                    res_next.out_fw   = rd_entry.fw;
                    res_next.out_nat  = rd_entry.nat;
                    state_next        = ST_DONE;
                end
                else if (issue_cnt_reg == fill_reg)
                begin
                    // every written entry checked
                    res_next          = '0;
                    res_next.status   = STATUS_NOMATCH;
                    res_next.echo_id  = qry_reg.query_id;
                    res_next.out_dist = -8'sd1;
                    state_next        = ST_DONE;
                end
                else
                begin
                    ram_rd_en      = 1'b1;
                    rd_ptr_next    = (rd_ptr_reg == '0) ? LAST_SLOT
                                   : rd_ptr_reg - PTR_W'(1);
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            magic_reg     <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            rd_ptr_reg    <= '0;
            issue_cnt_reg <= '0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            rd_ptr_reg    <= rd_ptr_next;
            issue_cnt_reg <= issue_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                magic_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        qry_reg <= qry_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/frrc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "flow_result_ring_cache_unit_macros.svh"

module frrc_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [31:0]         cfg_wr_data,
    input  wire logic                req_valid,
    input  wire logic                req_stall,
    input  wire frrc_pkg::frrc_req_t req,
    input  wire logic                rsp_valid,
    input  wire logic                rsp_stall,
    input  wire frrc_pkg::frrc_rsp_t rsp
);

    import frrc_pkg::*;

    logic req_query_beat;
    logic rsp_not_ok;
    logic rsp_record_zero;
    logic cfg_seen;

    assign req_query_beat  = req_valid && !req_stall && (req.kind == KIND_QUERY);
    assign rsp_not_ok      = rsp_valid && (rsp.status != STATUS_OK);
    assign rsp_record_zero = (rsp.out_sig == '0) && (rsp.out_link == '0)
                          && (rsp.out_tos == '0) && !rsp.out_fw && !rsp.out_nat;
    assign cfg_seen        = cfg_wr_en || (cfg_wr_data != cfg_wr_data);

    // a stalled response beat holds
    `FRRC_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // a query blocks further requests while it is searched
    `FRRC_ASSERT_NXT(a_query_stalls, clk, rst_n, req_query_beat && !cfg_seen, req_stall)

    // a new response only comes out of a query in flight
    `FRRC_ASSERT_IMP(a_rsp_from_query, clk, rst_n, $rose(rsp_valid), $past(req_stall))

    // miss and bad query carry an empty record, out_dist apart
    `FRRC_ASSERT_IMP(a_miss_empty, clk, rst_n, rsp_not_ok, rsp_record_zero)

endmodule

bind flow_result_ring_cache_unit frrc_checker u_frrc_checker (.*);

`default_nettype wire

// ----- tb/flow_result_ring_cache_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels and the magic register, keeps its own copy of the flow
// table and compares every response beat with the oldest predicted one.
module flow_result_ring_cache_checker #(
    parameter int unsigned DEPTH = frrc_pkg::DEFAULT_CACHE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                req_valid,
    input  logic                req_stall,
    input  frrc_pkg::frrc_req_t req,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  frrc_pkg::frrc_rsp_t rsp,
    output int                  mismatches,
    output int                  outstanding
);
    import frrc_pkg::*;

    // shadow flow table
    frrc_entry_t      flow_table [DEPTH];
    logic [DEPTH-1:0] slot_live   = '0;
    int               next_slot   = 0;
    logic [31:0]      magic       = '0;
    int               error_count = 0;
    frrc_rsp_t        expected_rsp [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // newest-first search of the shadow table
    function automatic frrc_rsp_t lookup_flow(frrc_req_t q);
        frrc_rsp_t r;
        int        idx;
        r = '0;
        r.echo_id = q.query_id;
        if (q.magic_word != magic)
        begin
            r.status = STATUS_BADQUERY;
            return r;
        end
        r.status   = STATUS_NOMATCH;
        r.out_dist = -8'sd1;
        for (int i = 1; i <= int'(DEPTH); i++)
        begin
            idx = (next_slot + int'(DEPTH) - i) % int'(DEPTH);
            if (slot_live[idx] && flow_table[idx].src == q.src_addr &&
                flow_table[idx].dst == q.dst_addr && flow_table[idx].ports == q.port_pair)
            begin
                r.status   = STATUS_OK;
                r.out_sig  = flow_table[idx].sig;
                r.out_link = flow_table[idx].link;
                r.out_tos  = flow_table[idx].tos;
                r.out_dist = flow_table[idx].hop;
                r.out_fw   = flow_table[idx].fw;
                r.out_nat  = flow_table[idx].nat;
                return r;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // update the shadow state on every accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        frrc_rsp_t exp_rsp;
        if (!rst_n)
        begin
            slot_live = '0;
            next_slot = 0;
            magic     = '0;
            expected_rsp.delete();
        end
        else
        begin
            // response side
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t ns: response beat with none expected, actual %h",
                             $time, rsp);
                    error_count++;
                end
                else
                begin
                    exp_rsp = expected_rsp.pop_front();
                    check_field("status",   32'(exp_rsp.status),   32'(rsp.status));
                    check_field("echo_id",  exp_rsp.echo_id,       rsp.echo_id);
                    check_field("out_sig",  32'(exp_rsp.out_sig),  32'(rsp.out_sig));
                    check_field("out_link", 32'(exp_rsp.out_link), 32'(rsp.out_link));
                    check_field("out_tos",  32'(exp_rsp.out_tos),  32'(rsp.out_tos));
                    check_field("out_dist", 32'(exp_rsp.out_dist), 32'(rsp.out_dist));
                    check_field("out_fw",   32'(exp_rsp.out_fw),   32'(rsp.out_fw));
                    check_field("out_nat",  32'(exp_rsp.out_nat),  32'(rsp.out_nat));
                end
            end

            // request side
            if (req_valid && !req_stall)
            begin
                if (req.kind == KIND_ADD)
                begin
                    flow_table[next_slot] = '{src: req.src_addr, dst: req.dst_addr,
                                              ports: req.port_pair, sig: req.sig_index,
                                              link: req.link_index, tos: req.tos_index,
                                              hop: req.hop_dist, fw: req.fw_flag,
                                              nat: req.nat_flag};
                    slot_live[next_slot] = 1'b1;
                    next_slot = (next_slot + 1) % int'(DEPTH);
                end
                else
                begin
                    expected_rsp.push_back(lookup_flow(req));
                end
            end

            if (cfg_wr_en)
                magic = cfg_wr_data;
        end
        mismatches  <= error_count;
        outstanding <= expected_rsp.size();
    end

endmodule

// ----- tb/tb_flow_result_ring_cache_unit.sv -----
`timescale 1ns / 1ps

module tb_flow_result_ring_cache_unit;
    import frrc_pkg::*;

    localparam int unsigned DEPTH       = DEFAULT_CACHE_DEPTH;
    localparam int          KEY_POOL    = 24;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASE_ITEMS = 450;

    localparam logic [95:0] KEY_ZERO  = 96'h0;
    localparam logic [95:0] KEY_MIXED = {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_0000};
    localparam logic [95:0] KEY_INV   = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF};
    localparam logic [95:0] KEY_ONES  = {96{1'b1}};

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        req_valid   = 1'b0;
    frrc_req_t   req         = '0;
    logic        req_stall;
    logic        rsp_valid;
    logic        rsp_stall   = 1'b0;
    frrc_rsp_t   rsp;
    int          mismatches;
    int          outstanding;

    // traffic shaping
    int          send_idle_pct = 0;
    int          rcv_idle_pct  = 0;
    int          hold_req      = 0;
    logic [31:0] cur_magic     = '0;
    logic [95:0] key_pool [KEY_POOL];

    flow_result_ring_cache_unit #(
        .CACHE_DEPTH(DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

    flow_result_ring_cache_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always #1 clk = ~clk;

    // watchdog
    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stall, plus a long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    function automatic logic [95:0] random_key();
        return {$urandom, $urandom, $urandom};
    endfunction

    // beat with every bit random
    function automatic frrc_req_t random_fill();
        logic [223:0] bits;
        frrc_req_t    b;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        b = bits[$bits(frrc_req_t)-1:0];
        return b;
    endfunction

    function automatic frrc_req_t add_beat(input logic [95:0] key, input logic [15:0] sig,
                                           input logic [7:0] link, input logic [7:0] tos,
                                           input logic [7:0] hop, input logic fw,
                                           input logic nat);
        frrc_req_t b;
        b = random_fill();
        b.kind = KIND_ADD;
        {b.src_addr, b.dst_addr, b.port_pair} = key;
        b.sig_index  = sig;
        b.link_index = link;
        b.tos_index  = tos;
        b.hop_dist   = hop;
        b.fw_flag    = fw;
        b.nat_flag   = nat;
        return b;
    endfunction

    function automatic frrc_req_t query_beat(input logic [95:0] key, input logic [31:0] magic);
        frrc_req_t b;
        b = random_fill();
        b.kind = KIND_QUERY;
        {b.src_addr, b.dst_addr, b.port_pair} = key;
        b.magic_word = magic;
        return b;
    endfunction

    // mostly pooled keys so queries hit, some near misses and strangers
    function automatic frrc_req_t random_beat();
        frrc_req_t   b;
        logic [95:0] key;
        logic [31:0] magic;
        int          pick;
        int          roll;
        pick = $urandom_range(KEY_POOL - 1);
        if ($urandom_range(99) < 45)
        begin
            if ($urandom_range(9) == 0)
                key_pool[pick] = random_key();
            b = random_fill();
            b.kind = KIND_ADD;
            {b.src_addr, b.dst_addr, b.port_pair} = key_pool[pick];
            return b;
        end
        roll = $urandom_range(99);
        if (roll < 8)
            key = random_key();
        else if (roll < 14)
            key = key_pool[pick] ^ (96'd1 << $urandom_range(95));
        else
            key = key_pool[pick];
        if ($urandom_range(99) < 15)
        begin
            if ($urandom_range(1) == 0)
                magic = cur_magic ^ (32'd1 << $urandom_range(31));
            else
                magic = cur_magic ^ ($urandom | 32'd1);
        end
        else
            magic = cur_magic;
        return query_beat(key, magic);
    endfunction

    // offer one beat and hold it until accepted
    task automatic send_beat(input frrc_req_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= b;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // stop offering until every expected response has come
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_magic(input logic [31:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cur_magic    = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int send_pct, input int rcv_pct);
        send_idle_pct = send_pct;
        rcv_idle_pct <= rcv_pct;
        for (int n = 0; n < count; n++)
            send_beat(random_beat());
    endtask

    // stimulus
    initial
    begin
        key_pool[0] = KEY_ZERO;
        key_pool[1] = KEY_ONES;
        for (int k = 2; k < KEY_POOL; k++)
            key_pool[k] = random_key();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset magic, empty table, extremes, newest wins
        send_beat(query_beat(KEY_ZERO, 32'h0));
        send_beat(query_beat(KEY_MIXED, 32'hFFFF_FFFF));
        send_beat(add_beat(KEY_MIXED, 16'hFFFF, 8'hFF, 8'hFF, 8'h80, 1'b1, 1'b1));
        send_beat(add_beat(KEY_ZERO, 16'h0, 8'h0, 8'h0, 8'h7F, 1'b0, 1'b0));
        send_beat(query_beat(KEY_MIXED, 32'h0));
        send_beat(query_beat(KEY_ZERO, 32'h0));
        send_beat(add_beat(KEY_MIXED, 16'h0001, 8'h02, 8'h03, 8'hFF, 1'b0, 1'b1));
        send_beat(query_beat(KEY_MIXED, 32'h0));
        send_beat(query_beat(KEY_MIXED ^ 96'd1, 32'h0));
        send_beat(query_beat(KEY_ZERO, 32'h1));
        write_magic(32'hFFFF_FFFF);
        send_beat(query_beat(KEY_ZERO, 32'hFFFF_FFFF));
        send_beat(query_beat(KEY_MIXED, 32'h0));
        send_beat(add_beat(KEY_INV, 16'h8000, 8'h80, 8'h01, 8'h00, 1'b1, 1'b0));
        send_beat(query_beat(KEY_INV, 32'hFFFF_FFFF));
        send_beat(query_beat(KEY_ONES, 32'hFFFF_FFFF));

        // random traffic under several magic settings and idle patterns
        write_magic($urandom);
        run_phase(PHASE_ITEMS, 35, 73);
        write_magic(32'h0);
        run_phase(PHASE_ITEMS, 73, 35);
        write_magic($urandom);
        hold_req <= hold_req + 1;
        run_phase(PHASE_ITEMS, 0, 0);

        drain();
        repeat (32) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
